@@ sv/ultrasonic_echo_range_timer_macros.svh @@
// Assertion macros for the echo range timer.
// Included by the RTL files that carry concurrent assertions; no other dependencies.
`ifndef ULTRASONIC_ECHO_RANGE_TIMER_MACROS_SVH
`define ULTRASONIC_ECHO_RANGE_TIMER_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define UERT_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("uert assertion failed");

// Next-cycle implication, disabled during reset.
`define UERT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("uert assertion failed");

`endif

@@ sv/uert_pkg.sv @@
// Shared types and constants for the echo range timer.
// No dependencies; imported by uert_ctrl, the top level, the checker and the testbench.
package uert_pkg;

    typedef enum logic [3:0] {
        PH_IDLE = 4'b0001,
        PH_TRIG = 4'b0010,
        PH_WAIT = 4'b0100,
        PH_HIGH = 4'b1000
    } phase_t;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_RANGE   = 2'd1,
        ST_TIMEOUT = 2'd2
    } status_t;

    localparam logic [7:0] CFG_TRIGGER_WIDTH = 8'd0;
    localparam logic [7:0] CFG_MIN_ECHO      = 8'd1;
    localparam logic [7:0] CFG_MAX_ECHO      = 8'd2;
    localparam logic [7:0] CFG_TIMEOUT_MARGIN = 8'd3;

    localparam int          SINCE_BITS = 17;
    localparam logic [16:0] SINCE_MAX  = 17'h1FFFF;
    localparam logic [10:0] DIST_SCALE = 11'd1114;
    localparam int          DIST_BITS  = 19;
    localparam int          PROD_BITS  = 27;

    typedef struct packed {
        logic [7:0]  trigger_width;
        logic [15:0] min_echo;
        logic [15:0] max_echo;
        logic [15:0] timeout_margin;
    } cfg_t;

    typedef struct packed {
        logic                 trigger_level;
        logic                 done_res;
        status_t              status;
        logic [DIST_BITS-1:0] distance_q8_cm;
        logic                 busy_res;
    } result_t;

endpackage

@@ sv/uert_ctrl.sv @@
// Measurement sequencer: phase, trigger/echo counters and result computation.
// Depends on uert_pkg and ultrasonic_echo_range_timer_macros.svh.
`include "ultrasonic_echo_range_timer_macros.svh"

module uert_ctrl #(
    parameter int COUNT_BITS = 16
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             accept,
    input  logic             start_req,
    input  logic             tick,
    input  logic             echo_level,
    input  uert_pkg::cfg_t    cfg,
    output uert_pkg::result_t res
);
    import uert_pkg::*;

    localparam logic [COUNT_BITS-1:0] WIDTH_MAX = {COUNT_BITS{1'b1}};

    phase_t                phase_reg, phase_next;
    logic [SINCE_BITS-1:0] since_reg, since_next, since_inc;
    logic [COUNT_BITS-1:0] width_reg, width_next;
    logic                  prev_echo_reg;
    logic                  rise, fall, in_band;
    logic [SINCE_BITS-1:0] limit;
    logic [31:0]           width_ext;
    logic [PROD_BITS-1:0]  product;

    assign rise      = !prev_echo_reg && echo_level;
    assign fall      = prev_echo_reg && !echo_level;
    assign since_inc = since_reg + 17'd1;
    assign limit     = {1'b0, cfg.max_echo} + {1'b0, cfg.timeout_margin};
    assign width_ext = 32'(width_next);
    assign in_band   = (width_ext >= 32'(cfg.min_echo)) && (width_ext <= 32'(cfg.max_echo));
    assign product   = PROD_BITS'(width_ext[15:0]) * PROD_BITS'(DIST_SCALE);

    always_comb
    begin
        phase_next         = phase_reg;
        since_next         = since_reg;
        width_next         = width_reg;
        res.done_res       = 1'b0;
        res.status         = ST_OK;
        res.distance_q8_cm = '0;
        unique case (phase_reg)
            PH_IDLE:
            begin
                if (start_req)
                begin
                    phase_next = PH_TRIG;
                    since_next = '0;
                    width_next = '0;
                end
            end
            PH_TRIG:
            begin
                if (tick)
                begin
                    if (since_inc >= SINCE_BITS'(cfg.trigger_width))
                    begin
                        phase_next = PH_WAIT;
                        since_next = '0;
                    end
                    else
                    begin
                        since_next = since_inc;
                    end
                end
            end
            PH_WAIT, PH_HIGH:
            begin
                if (tick)
                begin
                    if (since_reg != SINCE_MAX)
                    begin
                        since_next = since_inc;
                    end
                    if (phase_reg == PH_HIGH && width_reg != WIDTH_MAX)
                    begin
                        width_next = width_reg + COUNT_BITS'(1);
                    end
                end
                priority if (phase_reg == PH_HIGH && fall)
                begin
                    res.done_res = 1'b1;
                    phase_next   = PH_IDLE;
                    if (in_band)
                    begin
                        res.status         = ST_OK;
                        res.distance_q8_cm = product[PROD_BITS-1:8];
                    end
                    else
                    begin
                        res.status = ST_RANGE;
                    end
                end
                else if (since_next > limit)
                begin
                    res.done_res = 1'b1;
                    res.status   = ST_TIMEOUT;
                    phase_next   = PH_IDLE;
                end
                else if (phase_reg == PH_WAIT && rise)
                begin
                    phase_next = PH_HIGH;
                    width_next = '0;
                end
                else
                begin
                    phase_next = phase_reg;
                end
            end
            default:
            begin
                phase_next = PH_IDLE;
            end
        endcase
        res.trigger_level = (phase_next == PH_TRIG);
        res.busy_res      = (phase_next != PH_IDLE);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_IDLE;
            since_reg     <= '0;
            width_reg     <= '0;
            prev_echo_reg <= 1'b0;
        end
        else if (accept)
        begin
            phase_reg     <= phase_next;
            since_reg     <= since_next;
            width_reg     <= width_next;
            prev_echo_reg <= echo_level;
        end
    end

    `UERT_ASSERT_NEXT(a_start_enters_trigger, clk, rst_n,
        accept && phase_reg == PH_IDLE && start_req, phase_reg == PH_TRIG)
    `UERT_ASSERT_NEXT(a_hold_without_transaction, clk, rst_n,
        !accept, $stable(phase_reg) && $stable(since_reg) && $stable(width_reg))
    `UERT_ASSERT_NEXT(a_done_returns_idle, clk, rst_n,
        accept && res.done_res, phase_reg == PH_IDLE)
    `UERT_ASSERT_NOW(a_timeout_only_after_trigger, clk, rst_n,
        res.done_res && res.status == ST_TIMEOUT,
        phase_reg == PH_WAIT || phase_reg == PH_HIGH)

endmodule

@@ sv/ultrasonic_echo_range_timer.sv @@
// Top level of the ultrasonic echo range timer: config registers and output register.
// Depends on uert_pkg and uert_ctrl.
//
//   channel   direction  handshake              payload
//   in        input      in_valid / in_ready    start_req, tick, echo_level
//   out       output     out_valid / out_ready  trigger_level, done_res, status,
//                                               distance_q8_cm, busy_res
//   cfg       input      cfg_valid / cfg_ready  cfg_index, cfg_data
//
// One transaction per cycle unless the output stalls; each result appears the next cycle.
// in_ready is high while the output register is empty or being drained this cycle.
// An output stall holds the result and the sequencer state; nothing is dropped.
// Reset clears the phase and counters and loads the config defaults; cfg_ready is always high.
module ultrasonic_echo_range_timer #(
    parameter int COUNT_BITS = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        start_req,
    input  logic        tick,
    input  logic        echo_level,
    output logic        out_valid,
    input  logic        out_ready,
    output logic        trigger_level,
    output logic        done_res,
    output logic [1:0]  status,
    output logic [18:0] distance_q8_cm,
    output logic        busy_res,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [7:0]  cfg_index,
    input  logic [15:0] cfg_data
);
    import uert_pkg::*;

    cfg_t    cfg_reg;
    result_t res_next, res_reg;
    logic    out_valid_reg;
    logic    accept;

    assign in_ready  = !out_valid_reg || out_ready;
    assign accept    = in_valid && in_ready;
    assign cfg_ready = 1'b1;

    uert_ctrl #(
        .COUNT_BITS(COUNT_BITS)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .start_req (start_req),
        .tick      (tick),
        .echo_level(echo_level),
        .cfg       (cfg_reg),
        .res       (res_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.trigger_width  <= 8'd10;
            cfg_reg.min_echo       <= 16'd116;
            cfg_reg.max_echo       <= 16'd23529;
            cfg_reg.timeout_margin <= 16'd10000;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_TRIGGER_WIDTH:  cfg_reg.trigger_width  <= cfg_data[7:0];
                CFG_MIN_ECHO:       cfg_reg.min_echo       <= cfg_data;
                CFG_MAX_ECHO:       cfg_reg.max_echo       <= cfg_data;
                CFG_TIMEOUT_MARGIN: cfg_reg.timeout_margin <= cfg_data;
                default:            cfg_reg                <= cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            out_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            res_reg <= res_next;
        end
    end

    assign out_valid      = out_valid_reg;
    assign trigger_level  = res_reg.trigger_level;
    assign done_res       = res_reg.done_res;
    assign status         = 2'(res_reg.status);
    assign distance_q8_cm = res_reg.distance_q8_cm;
    assign busy_res       = res_reg.busy_res;

endmodule

@@ dv/echo_timer_checker.sv @@
// Scoreboard for the ultrasonic echo range timer: watches the input, output and register
// transactions, predicts each result and compares it field by field.
// Depends on uert_pkg for phase, status and result types.
module echo_timer_checker #(
    parameter int COUNT_BITS = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_ready,
    input  logic        start_req,
    input  logic        tick,
    input  logic        echo_level,
    input  logic        out_valid,
    input  logic        out_ready,
    input  logic        trigger_level,
    input  logic        done_res,
    input  logic [1:0]  status,
    input  logic [18:0] distance_q8_cm,
    input  logic        busy_res,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [7:0]  cfg_index,
    input  logic [15:0] cfg_data,
    output int          errors,
    output int          pending,
    output logic        meas_busy
);
    import uert_pkg::*;

    cfg_t                   regs;
    phase_t                 ph;
    logic [SINCE_BITS-1:0]  since_ticks;
    logic [COUNT_BITS-1:0]  high_ticks;
    logic                   last_echo;
    result_t                expected_readings[$];

    initial errors = 0;
    assign meas_busy = (ph != PH_IDLE);

    task automatic report_mismatch(input string what);
        $display("%0t: mismatch, %s", $time, what);
        errors++;
    endtask

    task automatic predict_echo_step(input logic s, input logic t, input logic e,
                                     output result_t r);
        logic                  rise;
        logic                  fall;
        logic [SINCE_BITS-1:0] limit;
        logic [63:0]           prod;
        rise = !last_echo && e;
        fall = last_echo && !e;
        r = '0;
        r.status = ST_OK;
        case (ph)
            PH_IDLE:
            begin
                if (s)
                begin
                    ph = PH_TRIG;
                    since_ticks = '0;
                    high_ticks = '0;
                end
            end
            PH_TRIG:
            begin
                if (t)
                begin
                    since_ticks = since_ticks + 1'b1;
                    if (since_ticks >= {9'd0, regs.trigger_width})
                    begin
                        ph = PH_WAIT;
                        since_ticks = '0;
                    end
                end
            end
            default:
            begin
                limit = {1'b0, regs.max_echo} + {1'b0, regs.timeout_margin};
                if (t)
                begin
                    if (since_ticks < SINCE_MAX)
                        since_ticks = since_ticks + 1'b1;
                    if (ph == PH_HIGH && high_ticks != '1)
                        high_ticks = high_ticks + 1'b1;
                end
                if (ph == PH_HIGH && fall)
                begin
                    r.done_res = 1'b1;
                    ph = PH_IDLE;
                    if (high_ticks >= regs.min_echo && high_ticks <= regs.max_echo)
                    begin
                        prod = 64'(high_ticks) * 64'(DIST_SCALE);
                        r.distance_q8_cm = prod[DIST_BITS+7:8];
                    end
                    else
                        r.status = ST_RANGE;
                end
                else if (since_ticks > limit)
                begin
                    r.done_res = 1'b1;
                    r.status = ST_TIMEOUT;
                    ph = PH_IDLE;
                end
                else if (ph == PH_WAIT && rise)
                begin
                    ph = PH_HIGH;
                    high_ticks = '0;
                end
            end
        endcase
        last_echo = e;
        r.trigger_level = (ph == PH_TRIG);
        r.busy_res = (ph != PH_IDLE);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        result_t got;
        result_t want;
        result_t next_res;
        if (!rst_n)
        begin
            regs.trigger_width = 8'd10;
            regs.min_echo = 16'd116;
            regs.max_echo = 16'd23529;
            regs.timeout_margin = 16'd10000;
            ph = PH_IDLE;
            since_ticks = '0;
            high_ticks = '0;
            last_echo = 1'b0;
            expected_readings.delete();
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                got.trigger_level = trigger_level;
                got.done_res = done_res;
                got.status = status_t'(status);
                got.distance_q8_cm = distance_q8_cm;
                got.busy_res = busy_res;
                if (expected_readings.size() == 0)
                    report_mismatch("result transaction with nothing expected");
                else
                begin
                    want = expected_readings.pop_front();
                    if (got.trigger_level !== want.trigger_level)
                        report_mismatch($sformatf("trigger_level got %0d expected %0d",
                                                  got.trigger_level, want.trigger_level));
                    if (got.done_res !== want.done_res)
                        report_mismatch($sformatf("done_res got %0d expected %0d",
                                                  got.done_res, want.done_res));
                    if (got.status !== want.status)
                        report_mismatch($sformatf("status got %0d expected %0d",
                                                  got.status, want.status));
                    if (got.distance_q8_cm !== want.distance_q8_cm)
                        report_mismatch($sformatf("distance_q8_cm got %0d expected %0d",
                                                  got.distance_q8_cm, want.distance_q8_cm));
                    if (got.busy_res !== want.busy_res)
                        report_mismatch($sformatf("busy_res got %0d expected %0d",
                                                  got.busy_res, want.busy_res));
                end
            end
            if (in_valid && in_ready)
            begin
                predict_echo_step(start_req, tick, echo_level, next_res);
                expected_readings.push_back(next_res);
            end
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_TRIGGER_WIDTH:  regs.trigger_width = cfg_data[7:0];
                    CFG_MIN_ECHO:       regs.min_echo = cfg_data;
                    CFG_MAX_ECHO:       regs.max_echo = cfg_data;
                    CFG_TIMEOUT_MARGIN: regs.timeout_margin = cfg_data;
                    default:            ;
                endcase
            end
        end
        pending = expected_readings.size();
    end

endmodule

@@ dv/testbench.sv @@
// Top of the echo range timer testbench: clock, reset, stimulus and verdict.
// Depends on uert_pkg, ultrasonic_echo_range_timer and echo_timer_checker.
module testbench;
    import uert_pkg::*;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic        start_req;
    logic        tick;
    logic        echo_level;
    logic        out_valid;
    logic        out_ready;
    logic        trigger_level;
    logic        done_res;
    logic [1:0]  status;
    logic [18:0] distance_q8_cm;
    logic        busy_res;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [7:0]  cfg_index;
    logic [15:0] cfg_data;
    int          errors;
    int          pending;
    logic        meas_busy;
    int          idle_pct;
    int          stall_pct;
    int          items_sent;
    int          trig_now;

    ultrasonic_echo_range_timer #(.COUNT_BITS(16)) dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .start_req(start_req), .tick(tick), .echo_level(echo_level),
        .out_valid(out_valid), .out_ready(out_ready),
        .trigger_level(trigger_level), .done_res(done_res), .status(status),
        .distance_q8_cm(distance_q8_cm), .busy_res(busy_res),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    echo_timer_checker #(.COUNT_BITS(16)) u_checker (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .start_req(start_req), .tick(tick), .echo_level(echo_level),
        .out_valid(out_valid), .out_ready(out_ready),
        .trigger_level(trigger_level), .done_res(done_res), .status(status),
        .distance_q8_cm(distance_q8_cm), .busy_res(busy_res),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data),
        .errors(errors), .pending(pending), .meas_busy(meas_busy)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #20_000_000;
        $display("testbench NOT OK");
        $finish;
    end

    always @(negedge clk)
        out_ready = (stall_pct == 0) || ($urandom_range(99) >= stall_pct);

    task automatic send_item(input logic s, input logic t, input logic e);
        while (idle_pct != 0 && $urandom_range(99) < idle_pct)
        begin
            in_valid = 1'b0;
            @(negedge clk);
        end
        in_valid = 1'b1;
        start_req = s;
        tick = t;
        echo_level = e;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        items_sent++;
        @(negedge clk);
    endtask

    task automatic burst(input int n, input int start_pct, input int tick_pct,
                         input int echo_pct);
        repeat (n)
            send_item($urandom_range(99) < start_pct, $urandom_range(99) < tick_pct,
                      $urandom_range(99) < echo_pct);
    endtask

    // finish any measurement in flight, then hold the sender until all results drain
    task automatic quiesce();
        logic lvl;
        lvl = 1'b0;
        while (meas_busy)
        begin
            send_item(1'b0, 1'b1, lvl);
            lvl = !lvl;
        end
        in_valid = 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (2) @(negedge clk);
    endtask

    task automatic write_reg(input logic [7:0] idx, input logic [15:0] val);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data = val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    task automatic load_setting(input logic [15:0] trig_data, input logic [15:0] min_v,
                                input logic [15:0] max_v, input logic [15:0] margin_v);
        quiesce();
        write_reg(CFG_TRIGGER_WIDTH, trig_data);
        write_reg(CFG_MIN_ECHO, min_v);
        write_reg(CFG_MAX_ECHO, max_v);
        write_reg(CFG_TIMEOUT_MARGIN, margin_v);
        // indexes past the register list must be dropped
        write_reg(8'($urandom_range(255, int'(CFG_TIMEOUT_MARGIN) + 1)), 16'($urandom));
        trig_now = trig_data[7:0];
    endtask

    initial
    begin
        int target;
        rst_n = 1'b0;
        in_valid = 1'b0;
        start_req = 1'b0;
        tick = 1'b0;
        echo_level = 1'b0;
        out_ready = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        idle_pct = 0;
        stall_pct = 0;
        items_sent = 0;
        trig_now = 10;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // reset defaults: start with tick, start while busy, in-range echo
        burst(1, 100, 100, 0);
        burst(1, 100, 100, 0);
        burst(11, 0, 100, 0);
        burst(120, 0, 100, 100);
        burst(1, 0, 100, 0);

        // zero trigger width behaves as one tick
        load_setting(16'hFF00, 16'd2, 16'd8, 16'd5);
        burst(1, 100, 100, 0);
        burst(1, 0, 100, 0);
        burst(6, 0, 100, 100);
        burst(1, 0, 100, 0);
        // echo exactly at the minimum
        burst(1, 100, 100, 0);
        burst(1, 0, 100, 0);
        burst(2, 0, 100, 100);
        burst(1, 0, 100, 0);
        // falling edge lands on the timeout item
        burst(1, 100, 100, 0);
        burst(1, 0, 100, 0);
        burst(13, 0, 100, 100);
        burst(1, 0, 100, 0);
        // echo already high when waiting starts, then timeout
        burst(2, 100, 100, 100);
        burst(3, 0, 100, 100);
        burst(20, 0, 100, 0);
        // sparse ticks
        burst(1, 100, 50, 0);
        burst(3, 0, 50, 0);
        burst(10, 0, 50, 100);
        burst(1, 0, 50, 0);

        // minimum above maximum
        load_setting(16'h0001, 16'd9, 16'd3, 16'd5);
        burst(1, 100, 100, 0);
        burst(1, 0, 100, 0);
        burst(6, 0, 100, 100);
        burst(1, 0, 100, 0);

        // zero-width echo with zero limits
        load_setting(16'h0001, 16'd0, 16'd0, 16'd0);
        burst(1, 100, 100, 0);
        burst(1, 0, 100, 0);
        burst(1, 0, 0, 100);
        burst(1, 0, 0, 0);
        burst(1, 100, 100, 0);
        burst(4, 0, 100, 0);

        // widest trigger with full-scale limits
        load_setting(16'h00FF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        burst(1, 100, 100, 0);
        burst(256, 0, 100, 0);
        burst(40, 0, 100, 100);
        burst(1, 0, 100, 0);

        for (int p = 0; p < 4; p++)
        begin
            case (p)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 65; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 65; end
                default: begin idle_pct = 32; stall_pct = 32; end
            endcase
            repeat (3)
            begin
                int tick_pct;
                load_setting({8'($urandom),
                              ($urandom_range(19) == 0) ? 8'd255 : 8'($urandom_range(6))},
                             16'($urandom_range(25)), 16'($urandom_range(60)),
                             16'($urandom_range(40)));
                tick_pct = $urandom_range(100, 50);
                target = items_sent + 50;
                while (items_sent < target)
                begin
                    if ($urandom_range(4) == 0)
                        burst($urandom_range(12, 1), 20, 50, 50);
                    else
                    begin
                        burst(1, 100, tick_pct, ($urandom_range(3) == 0) ? 100 : 0);
                        burst($urandom_range(trig_now + 8), 3, tick_pct, 0);
                        burst($urandom_range(70), 3, tick_pct, 100);
                        burst($urandom_range(4, 1), 3, tick_pct, 0);
                    end
                end
            end
        end

        quiesce();
        repeat (4) @(negedge clk);
        if (errors == 0)
            $display("testbench OK");
        else
            $display("testbench NOT OK");
        $finish;
    end

endmodule

@@ files.f @@
+incdir+sv
sv/uert_pkg.sv
sv/uert_ctrl.sv
sv/ultrasonic_echo_range_timer.sv
dv/echo_timer_checker.sv
dv/testbench.sv
